[src/closest_pair_two_point_sets_macros.svh]
// Assertion macros shared by the closest pair design.
`ifndef CLOSEST_PAIR_TWO_POINT_SETS_MACROS_SVH
`define CLOSEST_PAIR_TWO_POINT_SETS_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cpts_pkg.sv]
// Package with commands and controller states of the closest pair block.
package cpts_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_FETCH = 6'b001000,
    ST_SQRT  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

endpackage

[src/closest_pair_two_point_sets.sv]
// Top level of the brute-force closest pair search between two point sets.
//
//   channel | signals                       | direction
//   request | in_valid_i/in_ready_o, cmd_i  | in
//   result  | out_valid_o/out_ready_i, ...  | out
//
// Loads are accepted back to back while the block is idle.
// A compute runs the pairwise scan through the pipelined distance unit,
// then the bit-at-a-time square root, then moves into the result register.
// Both point memories have one read port each. No clearing pass follows reset.
// Requests stall while a compute runs, or while its result waits for an older
// result to leave the result register.
`include "closest_pair_two_point_sets_macros.svh"
module closest_pair_two_point_sets import cpts_pkg::*; #(
  parameter int DEPTH_A    = 1024,
  parameter int DEPTH_B    = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   cmd_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic signed [COORD_BITS-1:0] z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic                         overflow_o,
  output logic signed [COORD_BITS-1:0] a_x_o,
  output logic signed [COORD_BITS-1:0] a_y_o,
  output logic signed [COORD_BITS-1:0] a_z_o,
  output logic signed [COORD_BITS-1:0] b_x_o,
  output logic signed [COORD_BITS-1:0] b_y_o,
  output logic signed [COORD_BITS-1:0] b_z_o,
  output logic [2*COORD_BITS+1:0]      distance_sq_o,
  output logic [COORD_BITS:0]          distance_o
);

  localparam int CB   = COORD_BITS;
  localparam int PW   = 3 * CB;
  localparam int AW   = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
  localparam int BW   = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
  localparam int CAW  = $clog2(DEPTH_A + 1);
  localparam int CBW  = $clog2(DEPTH_B + 1);
  localparam int DW   = CB + 1;
  localparam int SW   = 2 * CB + 2;
  localparam int QW   = CB + 1;
  localparam int SQW  = $clog2(QW + 1);

  logic [PW-1:0] mem_a [DEPTH_A];
  logic [PW-1:0] mem_b [DEPTH_B];

  state_e state_q, state_d;
  logic [CAW-1:0] cnt_a_q;
  logic [CBW-1:0] cnt_b_q;
  logic           ovf_q;
  logic [AW-1:0]  ia_q;
  logic [BW-1:0]  ib_q;
  logic           last_q;

  logic          accept_in;
  logic          do_load_a, do_load_b;
  logic          do_compute;
  logic [PW-1:0] in_pt;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept_in  = in_valid_i && in_ready_o;
  assign in_pt      = {z_i, y_i, x_i};
  assign do_load_a  = accept_in && (cmd_e'(cmd_i) == CMD_LOAD_A)
                      && (cnt_a_q < CAW'(DEPTH_A));
  assign do_load_b  = accept_in && (cmd_e'(cmd_i) == CMD_LOAD_B)
                      && (cnt_b_q < CBW'(DEPTH_B));
  assign do_compute = accept_in && (cmd_e'(cmd_i) == CMD_COMPUTE);

  // Read addresses: scan indices, or the winning pair during the fetch step.
  logic [AW-1:0] bi_q;
  logic [BW-1:0] bj_q;
  logic [AW-1:0] rda;
  logic [BW-1:0] rdb;
  logic [PW-1:0] pa_q, pb_q;
  assign rda = (state_q == ST_SCAN) ? ia_q : bi_q;
  assign rdb = (state_q == ST_SCAN) ? ib_q : bj_q;

  always_ff @(posedge clk_i) begin
    if (do_load_a) begin
      mem_a[cnt_a_q[AW-1:0]] <= in_pt;
    end
    if (do_load_b) begin
      mem_b[cnt_b_q[BW-1:0]] <= in_pt;
    end
    pa_q <= mem_a[rda];
    pb_q <= mem_b[rdb];
  end

  // Distance pipeline: read (s0), differences (s1), squares (s2), sum (s3).
  logic          v0_q, v1_q, v2_q, v3_q;
  logic [AW-1:0] i0_q, i1_q, i2_q, i3_q;
  logic [BW-1:0] j0_q, j1_q, j2_q, j3_q;
  logic          e0_q, e1_q, e2_q, e3_q;
  logic [DW-1:0] dx_q, dy_q, dz_q;
  logic [2*DW-1:0] sx_q, sy_q, sz_q;
  logic [SW-1:0] sum_q;
  logic [SW-1:0] best_q;
  logic          have_q;

  function automatic logic [DW-1:0] absdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic signed [DW-1:0] d;
    d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    absdiff = d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  always_ff @(posedge clk_i) begin
    i0_q <= ia_q; j0_q <= ib_q; e0_q <= last_q;
    i1_q <= i0_q; j1_q <= j0_q; e1_q <= e0_q;
    i2_q <= i1_q; j2_q <= j1_q; e2_q <= e1_q;
    i3_q <= i2_q; j3_q <= j2_q; e3_q <= e2_q;
    dx_q <= absdiff(pa_q[CB-1:0], pb_q[CB-1:0]);
    dy_q <= absdiff(pa_q[2*CB-1:CB], pb_q[2*CB-1:CB]);
    dz_q <= absdiff(pa_q[3*CB-1:2*CB], pb_q[3*CB-1:2*CB]);
    sx_q <= dx_q * dx_q;
    sy_q <= dy_q * dy_q;
    sz_q <= dz_q * dz_q;
    sum_q <= SW'(sx_q) + SW'(sy_q) + SW'(sz_q);
  end

  // Square root, one result bit per cycle.
  logic [SW-1:0]  rem_q;
  logic [QW-1:0]  root_q;
  logic [SQW-1:0] sqc_q;
  logic [SW-1:0]  trial;
  logic [QW-1:0]  cand;
  always_comb begin
    cand  = root_q | (QW'(1) << (sqc_q - SQW'(1)));
    trial = SW'(cand) * SW'(cand);
  end

  logic found_q;
  logic ovf_out_q;

  // Result register; a finished compute moves in once it is free.
  logic          out_valid_q;
  logic          out_load;
  logic          out_stall;
  logic          res_found_q;
  logic          res_ovf_q;
  logic [PW-1:0] res_a_q, res_b_q;
  logic [SW-1:0] res_dsq_q;
  logic [QW-1:0] res_root_q;

  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_stall = out_valid_o && !out_ready_i;

  // Counts saved at compute start; the live counts clear at once.
  logic [CAW-1:0] cnt_a_sv_q;
  logic [CBW-1:0] cnt_b_sv_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (do_compute) begin
          state_d = (cnt_a_q != '0 && cnt_b_q != '0) ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN:  if (last_q) state_d = ST_DRAIN;
      ST_DRAIN: if (v3_q && e3_q) state_d = ST_FETCH;
      ST_FETCH: state_d = ST_SQRT;
      ST_SQRT:  if (sqc_q == SQW'(1)) state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ovf_q   <= 1'b0;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      ia_q    <= '0;
      ib_q    <= '0;
      last_q  <= 1'b0;
      have_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v0_q <= (state_q == ST_SCAN);
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (do_load_a) cnt_a_q <= cnt_a_q + CAW'(1);
      if (do_load_b) cnt_b_q <= cnt_b_q + CBW'(1);
      if (accept_in && (cmd_e'(cmd_i) == CMD_LOAD_A) && !do_load_a) ovf_q <= 1'b1;
      if (accept_in && (cmd_e'(cmd_i) == CMD_LOAD_B) && !do_load_b) ovf_q <= 1'b1;
      if (do_compute) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
        ovf_q   <= 1'b0;
        ia_q    <= '0;
        ib_q    <= '0;
        have_q  <= 1'b0;
        last_q  <= (cnt_a_q == CAW'(1)) && (cnt_b_q == CBW'(1));
      end
      if (state_q == ST_SCAN) begin
        if (CBW'(ib_q) + CBW'(1) == cnt_b_sv_q) begin
          ib_q <= '0;
          ia_q <= ia_q + AW'(1);
          last_q <= (CAW'(ia_q) + CAW'(2) == cnt_a_sv_q) && (cnt_b_sv_q == CBW'(1));
        end else begin
          ib_q <= ib_q + BW'(1);
          last_q <= (CAW'(ia_q) + CAW'(1) == cnt_a_sv_q)
                    && (CBW'(ib_q) + CBW'(2) == cnt_b_sv_q);
        end
      end
      if (v3_q) have_q <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_compute) begin
      cnt_a_sv_q <= cnt_a_q;
      cnt_b_sv_q <= cnt_b_q;
      found_q    <= (cnt_a_q != '0 && cnt_b_q != '0);
      ovf_out_q  <= ovf_q;
      best_q     <= '0;
      bi_q       <= '0;
      bj_q       <= '0;
      root_q     <= '0;
    end
    // Strictly smaller replaces, so ties keep the earliest pair.
    if (v3_q && (!have_q || sum_q < best_q)) begin
      best_q <= sum_q;
      bi_q   <= i3_q;
      bj_q   <= j3_q;
    end
    if (state_q == ST_FETCH) begin
      rem_q  <= best_q;
      root_q <= '0;
      sqc_q  <= SQW'(QW);
    end
    if (state_q == ST_SQRT) begin
      if (trial <= rem_q) root_q <= cand;
      sqc_q <= sqc_q - SQW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_found_q <= found_q;
      res_ovf_q   <= ovf_out_q;
      res_a_q     <= found_q ? pa_q : '0;
      res_b_q     <= found_q ? pb_q : '0;
      res_dsq_q   <= found_q ? best_q : '0;
      res_root_q  <= found_q ? root_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = res_found_q;
  assign overflow_o    = res_ovf_q;
  assign a_x_o         = res_a_q[CB-1:0];
  assign a_y_o         = res_a_q[2*CB-1:CB];
  assign a_z_o         = res_a_q[3*CB-1:2*CB];
  assign b_x_o         = res_b_q[CB-1:0];
  assign b_y_o         = res_b_q[2*CB-1:CB];
  assign b_z_o         = res_b_q[3*CB-1:2*CB];
  assign distance_sq_o = res_dsq_q;
  assign distance_o    = res_root_q;

  `CP_ASSERT_IMP(a_no_load_busy, state_q != ST_IDLE, !do_load_a && !do_load_b, "load while busy")
  `CP_ASSERT_NEXT(a_out_holds, out_stall, out_valid_o && $stable(distance_sq_o), "result not held")
  `CP_ASSERT_IMP(a_count_a_bound, 1'b1, cnt_a_q <= CAW'(DEPTH_A), "count A past depth")
  `CP_ASSERT_NEXT(a_clear, do_compute, cnt_a_q == '0 && cnt_b_q == '0 && !ovf_q, "not cleared")

endmodule

[tb/tb.sv]
// Self-checking testbench for the two-set closest pair search block.
module tb import cpts_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH_A = 1024;
  localparam int DEPTH_B = 1024;
  localparam int CB = 24;
  localparam int SW = 2 * CB + 2;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RAND_ITEMS = 220;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t x, y, z;
  } point_t;
  typedef struct {
    cmd_e   cmd;
    point_t p;
    bit     hold;  // wait until every outstanding result has come back
  } request_t;
  typedef struct {
    logic found, ovf;
    point_t a, b;
    logic [2*CB+1:0] dsq;
    logic [CB:0] root;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = '0;
  coord_t x_i = '0, y_i = '0, z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic found_o, overflow_o;
  coord_t a_x_o, a_y_o, a_z_o, b_x_o, b_y_o, b_z_o;
  logic [2*CB+1:0] distance_sq_o;
  logic [CB:0] distance_o;

  closest_pair_two_point_sets #(.DEPTH_A(DEPTH_A), .DEPTH_B(DEPTH_B), .COORD_BITS(CB)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .x_i, .y_i, .z_i,
    .out_valid_o, .out_ready_i, .found_o, .overflow_o, .a_x_o, .a_y_o, .a_z_o,
    .b_x_o, .b_y_o, .b_z_o, .distance_sq_o, .distance_o
  );

  always #5 clk_i = ~clk_i;

  request_t req_q[$];
  pair_t    pair_q[$];
  int errors = 0;

  // Predictor state.
  point_t set_a[DEPTH_A];
  point_t set_b[DEPTH_B];
  int cnt_a = 0, cnt_b = 0;
  bit dropped = 0;

  function automatic logic [2*CB+1:0] sq_dist(point_t p, point_t q);
    longint dx, dy, dz;
    dx = longint'(p.x) - longint'(q.x);
    dy = longint'(p.y) - longint'(q.y);
    dz = longint'(p.z) - longint'(q.z);
    return SW'(dx * dx + dy * dy + dz * dz);
  endfunction

  function automatic logic [CB:0] floor_root(logic [2*CB+1:0] v);
    longint unsigned r, t;
    r = 0;
    for (int b = CB; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return (CB + 1)'(r);
  endfunction

  task automatic apply_request(request_t r);
    pair_t res;
    logic [2*CB+1:0] d;
    case (r.cmd)
      CMD_LOAD_A: begin
        if (cnt_a < DEPTH_A) set_a[cnt_a++] = r.p;
        else dropped = 1;
      end
      CMD_LOAD_B: begin
        if (cnt_b < DEPTH_B) set_b[cnt_b++] = r.p;
        else dropped = 1;
      end
      CMD_COMPUTE: begin
        res = '{found: 0, ovf: dropped, a: '{0, 0, 0}, b: '{0, 0, 0}, dsq: 0, root: 0};
        if (cnt_a != 0 && cnt_b != 0) begin
          res.found = 1;
          res.a = set_a[0];
          res.b = set_b[0];
          res.dsq = sq_dist(set_a[0], set_b[0]);
          // Strictly closer only, so ties keep the earliest pair in A-major order.
          for (int i = 0; i < cnt_a; i++)
            for (int j = 0; j < cnt_b; j++) begin
              d = sq_dist(set_a[i], set_b[j]);
              if (d < res.dsq) begin
                res.dsq = d;
                res.a = set_a[i];
                res.b = set_b[j];
              end
            end
          res.root = floor_root(res.dsq);
        end
        pair_q.push_back(res);
        cnt_a = 0;
        cnt_b = 0;
        dropped = 0;
      end
      default: ;
    endcase
  endtask

  // Driver: bursts of requests separated by random gaps.
  int gap = 0, burst = 0;
  request_t cur;
  always @(posedge clk_i or negedge rst_ni) begin
    bit fire, nv;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      fire = in_valid_i && in_ready_o;
      if (fire) apply_request(cur);
      if (!in_valid_i || fire) begin
        nv = 0;
        if (gap > 0) begin
          gap--;
        end else if (req_q.size() > 0 && !(req_q[0].hold && pair_q.size() > 0)) begin
          cur = req_q.pop_front();
          cmd_i <= cur.cmd;
          x_i <= cur.p.x;
          y_i <= cur.p.y;
          z_i <= cur.p.z;
          nv = 1;
          if (burst > 0) burst--;
          else begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid_i <= nv;
      end
    end
  end

  // Receiver stall pattern: runs of always ready, half ready, or mostly stalled.
  int stall_mode = 0, stall_len = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (stall_len == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_len = $urandom_range(5, 200);
      end else stall_len--;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on %s: got %0h, expected %0h (error %0d)", field, got, want, errors);
  endtask

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    pair_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pair_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        w = pair_q.pop_front();
        if (found_o !== w.found) report("found", found_o, w.found);
        if (overflow_o !== w.ovf) report("overflow", overflow_o, w.ovf);
        if (a_x_o !== w.a.x) report("a_x", a_x_o, w.a.x);
        if (a_y_o !== w.a.y) report("a_y", a_y_o, w.a.y);
        if (a_z_o !== w.a.z) report("a_z", a_z_o, w.a.z);
        if (b_x_o !== w.b.x) report("b_x", b_x_o, w.b.x);
        if (b_y_o !== w.b.y) report("b_y", b_y_o, w.b.y);
        if (b_z_o !== w.b.z) report("b_z", b_z_o, w.b.z);
        if (distance_sq_o !== w.dsq) report("distance_sq", distance_sq_o, w.dsq);
        if (distance_o !== w.root) report("distance", distance_o, w.root);
      end
    end
  end

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push(cmd_e c, coord_t x = 0, coord_t y = 0, coord_t z = 0, bit hold = 0);
    request_t r;
    r.cmd = c;
    r.p = '{x, y, z};
    r.hold = hold;
    req_q.push_back(r);
  endtask

  function automatic coord_t rnd_coord(bit near, coord_t base);
    if (near) return base + coord_t'($urandom_range(0, 6)) - coord_t'(3);
    return coord_t'($urandom());
  endfunction

  initial begin
    coord_t mx, mn, base;
    int na, nb, n, tot;
    bit near;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};

    // Directed: empty sets, one empty set, extremes, ties, unused command.
    push(CMD_COMPUTE);
    push(CMD_LOAD_A, 5, 6, 7);
    push(CMD_COMPUTE);
    push(CMD_LOAD_B, 1, 2, 3);
    push(CMD_COMPUTE);
    push(CMD_LOAD_A, mn, mn, mn);
    push(CMD_LOAD_B, mx, mx, mx);
    push(CMD_COMPUTE);
    push(CMD_LOAD_A, 0, 0, 0);
    push(CMD_LOAD_A, 0, 0, 0);
    push(CMD_LOAD_B, 1, 0, 0);
    push(CMD_LOAD_B, -1, 0, 0);
    push(CMD_NONE, -1, -1, -1);
    push(CMD_COMPUTE);
    // The next load waits until the result before it has been taken.
    push(CMD_LOAD_A, mx, mn, -1, 1);
    push(CMD_LOAD_B, mx, mn, -1);
    push(CMD_COMPUTE, 0, 0, 0, 1);

    // Fill set A past capacity, then load a modest set B.
    push(CMD_LOAD_B, 100, -100, 7);
    push(CMD_LOAD_B, 0, 0, 0);
    for (int i = 0; i < DEPTH_A + 3; i++)
      push(CMD_LOAD_A, coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
    push(CMD_COMPUTE);
    push(CMD_LOAD_A, -5, 9, 3);
    for (int i = 0; i < 20; i++)
      push(CMD_LOAD_B, coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
    push(CMD_COMPUTE);

    // Random sets; clustered coordinates make near ties likely.
    n = 0;
    while (n < RAND_ITEMS) begin
      na = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      nb = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      near = $urandom_range(0, 1);
      base = coord_t'($urandom());
      tot = na + nb;
      for (int i = 0; i < tot; i++) begin
        push((i % 2 == 0 && na > 0) || nb == 0 ? CMD_LOAD_A : CMD_LOAD_B,
             rnd_coord(near, base), rnd_coord(near, base), rnd_coord(near, base));
        if (req_q[$].cmd == CMD_LOAD_A) na--; else nb--;
        if ($urandom_range(0, 19) == 0) push(CMD_NONE, coord_t'($urandom()));
        n++;
      end
      push(CMD_COMPUTE, coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
           $urandom_range(0, 15) == 0);
      n++;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (req_q.size() == 0 && !in_valid_i && pair_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

[sim.f]
+incdir+src
src/cpts_pkg.sv
src/closest_pair_two_point_sets.sv
tb/tb.sv
